// ===== rtl/core/cfrs_pkg.sv =====
// Shared types and codes for the chunked file read sequencer.
// No dependencies; used by every module under rtl/core except cfrs_store.
package cfrs_pkg;

  // input item kinds
  localparam logic [2:0] KIND_START  = 3'd0;
  localparam logic [2:0] KIND_SELSW  = 3'd1;
  localparam logic [2:0] KIND_DATA   = 3'd2;
  localparam logic [2:0] KIND_EMPTY  = 3'd3;
  localparam logic [2:0] KIND_FETCH  = 3'd4;

  // result kinds
  localparam logic [1:0] RK_SELECT = 2'd0;
  localparam logic [1:0] RK_READ   = 2'd1;
  localparam logic [1:0] RK_DONE   = 2'd2;
  localparam logic [1:0] RK_FETCH  = 2'd3;

  // done status codes
  localparam logic [1:0] DS_OK       = 2'd0;
  localparam logic [1:0] DS_SEL_FAIL = 2'd1;
  localparam logic [1:0] DS_NO_DATA  = 2'd2;
  localparam logic [1:0] DS_LIMIT    = 2'd3;

  // result staged between the sequencer and the output queue
  typedef struct packed {
    logic [1:0]  rkind;
    logic [15:0] fid;
    logic [6:0]  p1;
    logic [7:0]  p2;
    logic [1:0]  status;
    logic [15:0] len;
    logic        fetch_ok;   // fetched byte comes from the store read port
  } res_t;

  // entry as it sits in the output queue
  typedef struct packed {
    logic [1:0]  rkind;
    logic [15:0] fid;
    logic [6:0]  p1;
    logic [7:0]  p2;
    logic [1:0]  status;
    logic [15:0] len;
    logic [7:0]  fbyte;
  } out_t;

endpackage

// ===== rtl/core/chunked_file_read_sequencer_core.sv =====
// Top level of the chunked file read sequencer.
// Uses cfrs_pkg, cfrs_ctrl, cfrs_store and cfrs_outq.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   input    | in_valid / in_stall  | kind, file_id, skip_select, select_sw1,
//            |                      | data_byte, chunk_last, fetch_index
//   result   | out_valid / out_stall| result_kind, select_fid, read_p1, read_p2,
//            |                      | done_status, file_length, fetched_byte
//
// One item per cycle while in_stall is low. A result passes through the result
// stage register (the store read register runs beside it) and the output queue.
// The sequencer state updates in the cycle of transfer; items follow back to back.
// in_stall rises once three results wait or are in flight; the queue absorbs them.
// Reset clears phase, counters and header state; the store is not cleared.
module chunked_file_read_sequencer_core #(
  parameter int MAX_BYTES = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_file_id,
  input  logic        in_skip_select,
  input  logic [7:0]  in_select_sw1,
  input  logic [7:0]  in_data_byte,
  input  logic        in_chunk_last,
  input  logic [14:0] in_fetch_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_select_fid,
  output logic [6:0]  out_read_p1,
  output logic [7:0]  out_read_p2,
  output logic [1:0]  out_done_status,
  output logic [15:0] out_file_length,
  output logic [7:0]  out_fetched_byte
);

  localparam int AW = $clog2(MAX_BYTES);

  logic           acc;
  logic           we, re;
  logic [AW-1:0]  waddr, raddr;
  logic [7:0]     wdata, rdata;
  logic           s_v;
  cfrs_pkg::res_t s_res;
  cfrs_pkg::out_t head;

  assign acc = in_valid && !in_stall;

  cfrs_ctrl #(.MAX_BYTES(MAX_BYTES)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .kind        (in_kind),
    .file_id     (in_file_id),
    .skip_select (in_skip_select),
    .select_sw1  (in_select_sw1),
    .data_byte   (in_data_byte),
    .chunk_last  (in_chunk_last),
    .fetch_index (in_fetch_index),
    .we          (we),
    .waddr       (waddr),
    .wdata       (wdata),
    .re          (re),
    .raddr       (raddr),
    .s_v_r       (s_v),
    .s_res_r     (s_res)
  );

  cfrs_store #(.MAX_BYTES(MAX_BYTES)) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  cfrs_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_v       (s_v),
    .s_res     (s_res),
    .rdata     (rdata),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_result_kind  = head.rkind;
  assign out_select_fid   = head.fid;
  assign out_read_p1      = head.p1;
  assign out_read_p2      = head.p2;
  assign out_done_status  = head.status;
  assign out_file_length  = head.len;
  assign out_fetched_byte = head.fbyte;

endmodule

// ===== rtl/core/cfrs_store.sv =====
// File byte store: one write port, one registered read port.
// Depends on nothing but its parameter.
module cfrs_store #(
  parameter int MAX_BYTES = 32768,
  localparam int AW = $clog2(MAX_BYTES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata_r
);

  logic [7:0] mem [MAX_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/cfrs_ctrl.sv =====
// Read sequencer: phase control, incremental BER header parse, store access.
// Uses cfrs_pkg; drives the store ports and a registered result stage.
module cfrs_ctrl #(
  parameter int MAX_BYTES = 32768,
  localparam int AW = $clog2(MAX_BYTES),
  localparam int CW = $clog2(MAX_BYTES + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic [2:0]      kind,
  input  logic [15:0]     file_id,
  input  logic            skip_select,
  input  logic [7:0]      select_sw1,
  input  logic [7:0]      data_byte,
  input  logic            chunk_last,
  input  logic [14:0]     fetch_index,
  output logic            we,
  output logic [AW-1:0]   waddr,
  output logic [7:0]      wdata,
  output logic            re,
  output logic [AW-1:0]   raddr,
  output logic            s_v_r,
  output cfrs_pkg::res_t  s_res_r
);

  typedef enum logic [1:0] {PH_IDLE, PH_SELECT, PH_READ} phase_t;

  typedef enum logic [2:0] {
    HS_TAG1, HS_TAGN, HS_LEN, HS_LEN3, HS_LEN2, HS_LEN1, HS_DONE, HS_BAD
  } hstage_t;

  typedef struct packed {
    hstage_t     stage;
    logic [15:0] pos;
    logic [23:0] acc;
  } hdr_t;

  localparam logic [7:0] TAG_NUM_MASK = 8'h1F;
  localparam logic [7:0] MORE_BIT     = 8'h80;
  localparam logic [7:0] LONG_1       = 8'h81;
  localparam logic [7:0] LONG_2       = 8'h82;
  localparam logic [7:0] LONG_3       = 8'h83;
  localparam logic [7:0] SW1_OK       = 8'h90;
  localparam logic [7:0] SW1_WARN     = 8'h62;

  function automatic hdr_t parse(input hdr_t h, input logic [7:0] b);
    hdr_t o;
    o = h;
    case (h.stage)
      HS_TAG1: begin
        o.stage = ((b & TAG_NUM_MASK) == TAG_NUM_MASK) ? HS_TAGN : HS_LEN;
        o.pos   = h.pos + 16'd1;
      end
      HS_TAGN: begin
        if ((b & MORE_BIT) == 8'h00) begin
          o.stage = HS_LEN;
        end
        o.pos = h.pos + 16'd1;
      end
      HS_LEN: begin
        if (b < MORE_BIT) begin
          o.acc   = {16'd0, b};
          o.pos   = h.pos + 16'd1;
          o.stage = HS_DONE;
        end else if (b == LONG_1) begin
          o.acc   = '0;
          o.pos   = h.pos + 16'd2;
          o.stage = HS_LEN1;
        end else if (b == LONG_2) begin
          o.acc   = '0;
          o.pos   = h.pos + 16'd3;
          o.stage = HS_LEN2;
        end else if (b == LONG_3) begin
          o.acc   = '0;
          o.pos   = h.pos + 16'd4;
          o.stage = HS_LEN3;
        end else begin
          o.stage = HS_BAD;
        end
      end
      HS_LEN3: begin
        o.acc   = {h.acc[15:0], b};
        o.stage = HS_LEN2;
      end
      HS_LEN2: begin
        o.acc   = {h.acc[15:0], b};
        o.stage = HS_LEN1;
      end
      HS_LEN1: begin
        o.acc   = {h.acc[15:0], b};
        o.stage = HS_DONE;
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  phase_t         phase_r, phase_nxt;
  hdr_t           hdr_r, hdr_nxt, hdr_p;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [24:0]    total_r, total_nxt;
  logic           frozen_r, frozen_nxt;
  logic           res_v;
  cfrs_pkg::res_t res;
  logic           full;
  logic [14:0]    offset;

  assign full   = (32'(cnt_r) >= MAX_BYTES);
  assign hdr_p  = parse(hdr_r, data_byte);
  assign waddr  = cnt_r[AW-1:0];
  assign wdata  = data_byte;
  assign raddr  = fetch_index[AW-1:0];
  assign offset = 15'(cnt_nxt);

  always_comb begin
    phase_nxt  = phase_r;
    hdr_nxt    = hdr_r;
    cnt_nxt    = cnt_r;
    total_nxt  = total_r;
    frozen_nxt = frozen_r;
    res_v      = 1'b0;
    res        = '0;
    we         = 1'b0;
    re         = 1'b0;
    case (kind)
      cfrs_pkg::KIND_START: begin
        hdr_nxt    = '{stage: HS_TAG1, pos: 16'd0, acc: 24'd0};
        cnt_nxt    = '0;
        total_nxt  = '0;
        frozen_nxt = 1'b0;
        res_v      = 1'b1;
        if (skip_select) begin
          phase_nxt = PH_READ;
          res.rkind = cfrs_pkg::RK_READ;
        end else begin
          phase_nxt = PH_SELECT;
          res.rkind = cfrs_pkg::RK_SELECT;
          res.fid   = file_id;
        end
      end
      cfrs_pkg::KIND_SELSW: begin
        if (phase_r == PH_SELECT) begin
          res_v = 1'b1;
          if (select_sw1 == SW1_OK || select_sw1 == SW1_WARN) begin
            phase_nxt = PH_READ;
            res.rkind = cfrs_pkg::RK_READ;
          end else begin
            phase_nxt  = PH_IDLE;
            res.rkind  = cfrs_pkg::RK_DONE;
            res.status = cfrs_pkg::DS_SEL_FAIL;
          end
        end
      end
      cfrs_pkg::KIND_DATA: begin
        if (phase_r == PH_READ) begin
          if (!full) begin
            we      = acc;
            cnt_nxt = cnt_r + CW'(1);
            if (!frozen_r) begin
              hdr_nxt = hdr_p;
            end
          end
          if (chunk_last) begin
            res_v = 1'b1;
            if (!frozen_r && cnt_nxt >= CW'(4)) begin
              frozen_nxt = 1'b1;
              total_nxt  = (hdr_nxt.stage == HS_DONE)
                         ? (25'(hdr_nxt.pos) + 25'(hdr_nxt.acc)) : 25'd0;
            end
            if (total_nxt != 25'd0 && 25'(cnt_nxt) >= total_nxt) begin
              phase_nxt  = PH_IDLE;
              res.rkind  = cfrs_pkg::RK_DONE;
              res.status = cfrs_pkg::DS_OK;
              res.len    = total_nxt[15:0];
            end else if (32'(cnt_nxt) >= MAX_BYTES) begin
              phase_nxt  = PH_IDLE;
              res.rkind  = cfrs_pkg::RK_DONE;
              res.status = cfrs_pkg::DS_LIMIT;
              res.len    = 16'(MAX_BYTES);
            end else begin
              res.rkind = cfrs_pkg::RK_READ;
              res.p1    = offset[14:8];
              res.p2    = offset[7:0];
            end
          end
        end
      end
      cfrs_pkg::KIND_EMPTY: begin
        if (phase_r == PH_READ) begin
          phase_nxt = PH_IDLE;
          res_v     = 1'b1;
          res.rkind = cfrs_pkg::RK_DONE;
          if (cnt_r == '0) begin
            res.status = cfrs_pkg::DS_NO_DATA;
          end else begin
            res.status = cfrs_pkg::DS_OK;
            res.len    = 16'(cnt_r);
          end
        end
      end
      cfrs_pkg::KIND_FETCH: begin
        res_v        = 1'b1;
        res.rkind    = cfrs_pkg::RK_FETCH;
        res.fetch_ok = (32'(fetch_index) < MAX_BYTES);
        re           = acc && res.fetch_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      hdr_r    <= '{stage: HS_TAG1, pos: 16'd0, acc: 24'd0};
      cnt_r    <= '0;
      total_r  <= '0;
      frozen_r <= 1'b0;
      s_v_r    <= 1'b0;
    end else begin
      s_v_r <= acc && res_v;
      if (acc) begin
        phase_r  <= phase_nxt;
        hdr_r    <= hdr_nxt;
        cnt_r    <= cnt_nxt;
        total_r  <= total_nxt;
        frozen_r <= frozen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s_res_r <= res;
    end
  end

endmodule

// ===== rtl/core/cfrs_outq.sv =====
// Three-entry result queue that decouples the sequencer from the output stall.
// Uses cfrs_pkg; fed by the result stage of cfrs_ctrl and the store read data.
module cfrs_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s_v,
  input  cfrs_pkg::res_t s_res,
  input  logic [7:0]     rdata,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output cfrs_pkg::out_t head
);

  localparam int QD = 3;

  cfrs_pkg::out_t q_r [QD];
  logic [1:0]     wp_r, rp_r, cnt_r;
  logic [1:0]     wp_nxt, rp_nxt, cnt_nxt;
  logic           push, pop;
  cfrs_pkg::out_t ent;

  function automatic logic [1:0] inc(input logic [1:0] p);
    return (p == 2'(QD - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  always_comb begin
    ent.rkind  = s_res.rkind;
    ent.fid    = s_res.fid;
    ent.p1     = s_res.p1;
    ent.p2     = s_res.p2;
    ent.status = s_res.status;
    ent.len    = s_res.len;
    ent.fbyte  = s_res.fetch_ok ? rdata : 8'd0;
  end

  // one slot is held back for the result still in the stage ahead
  assign in_stall  = ({1'b0, cnt_r} + {2'b00, s_v}) >= 3'(QD);
  assign out_valid = (cnt_r != 2'd0);
  assign head      = q_r[rp_r];
  assign push      = s_v;
  assign pop       = out_valid && !out_stall;
  assign wp_nxt    = push ? inc(wp_r) : wp_r;
  assign rp_nxt    = pop ? inc(rp_r) : rp_r;
  assign cnt_nxt   = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= ent;
    end
  end

endmodule
